FILE: sv/rca_pkg.sv
// Shared types, constants and the micro-rotation angle table of the azimuth block.
package rca_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned COORD_BITS_DEF    = 17;
  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // Rotation datapath: magnitudes are scaled to just below 2^59, the gain
  // brings them under 2^61, one more bit holds the sign.
  localparam int unsigned GUARD_TOP  = 59;
  localparam int unsigned XY_BITS    = 62;
  // Angle accumulator in units of 2^-32 turn, signed with headroom.
  localparam int unsigned TURN_BITS  = 32;
  localparam int unsigned Z_BITS     = 34;
  localparam int unsigned MAX_STAGES = 32;

  // Configuration channel
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_VIEW_ROW = 2'd0,
    REG_VIEW_COL = 2'd1
  } cfg_reg_e;

  // Where the position lies relative to the viewpoint
  typedef enum logic [3:0] {
    KIND_VIEW    = 4'd0,
    KIND_AXIS_E  = 4'd1,
    KIND_AXIS_N  = 4'd2,
    KIND_AXIS_W  = 4'd3,
    KIND_AXIS_S  = 4'd4,
    KIND_QUAD_NE = 4'd5,
    KIND_QUAD_NW = 4'd6,
    KIND_QUAD_SW = 4'd7,
    KIND_QUAD_SE = 4'd8
  } kind_e;

  // Sideband that travels with each word down the chain
  typedef struct packed {
    logic  valid;
    kind_e kind;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn, rounded
  localparam logic [TURN_BITS-1:0] STAGE_ANGLE [MAX_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

FILE: sv/rca_pos_if.sv
// Position channel: valid/ready handshake carrying one raster position word.
interface rca_pos_if #(
  parameter int unsigned COORD_BITS = rca_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cell_row_half;
  logic [COORD_BITS-1:0] cell_col_half;

  modport source (output valid, output cell_row_half, output cell_col_half, input ready);
  modport sink   (input valid, input cell_row_half, input cell_col_half, output ready);
endinterface

FILE: sv/rca_azi_if.sv
// Azimuth channel: valid/ready handshake carrying one azimuth word.
interface rca_azi_if #(
  parameter int unsigned ANGLE_BITS = rca_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] azimuth;
  logic                  at_viewpoint;

  modport source (output valid, output azimuth, output at_viewpoint, input ready);
  modport sink   (input valid, input azimuth, input at_viewpoint, output ready);
endinterface

FILE: sv/rca_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying register index and data.
interface rca_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rca_pkg::CFG_IDX_BITS-1:0]   reg_index;
  logic [rca_pkg::CFG_DATA_BITS-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: sv/raster_cell_azimuth.sv
// Top level: viewpoint registers and the rotation chain of the azimuth block.
//
// Usage:
//   cfg_if  writes the viewpoint: index REG_VIEW_ROW, REG_VIEW_COL, low COORD_BITS-1
//           bits of the data in whole cells; other indexes are dropped. Always ready.
//           Write only while the block is idle.
//   pos_if  takes one raster position word (row and column in half cells) per cycle.
//   azi_if  returns one word per position, in order: azimuth as a fraction of a full
//           turn (2^ANGLE_BITS = one turn, rows grow downward) and at_viewpoint, set
//           with a zero azimuth when the position equals the viewpoint.
// Path: an accepted word loads into the front cell, passes through one cell per
//   micro-rotation and the output register, and then shows on azi_if.
// Throughput: one word per cycle while the chain is not stalled, set by the chain of cells advancing together.
// Stall: when azi_if stalls, the chain keeps moving until a word lands in the skid
//   stage behind the output register; pos_if.ready then drops until the skid
//   drains. pos_if.ready comes from a register, with no path from azi_if.ready.
// Reset: clears all valid bits and the viewpoint to row 0, column 0.
module raster_cell_azimuth #(
  parameter int unsigned COORD_BITS    = rca_pkg::COORD_BITS_DEF,
  parameter int unsigned ANGLE_BITS    = rca_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = rca_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rca_cfg_if.sink     cfg_if,
  rca_pos_if.sink     pos_if,
  rca_azi_if.source   azi_if
);

  logic [COORD_BITS-2:0] view_row_q, view_col_q;
  logic                  en;

  // Chain taps: index 0 is the front cell, index i+1 the output of cell i
  rca_pkg::side_t                     side_s [CORDIC_STAGES+1];
  logic signed [rca_pkg::XY_BITS-1:0] x_s    [CORDIC_STAGES];
  logic signed [rca_pkg::XY_BITS-1:0] y_s    [CORDIC_STAGES];
  logic signed [rca_pkg::Z_BITS-1:0]  z_s    [CORDIC_STAGES+1];

  // Config writes: decode the index, ignore unknown ones
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_row_q <= '0;
      view_col_q <= '0;
    end else if (cfg_if.valid) begin
      unique case (rca_pkg::cfg_reg_e'(cfg_if.reg_index))
        rca_pkg::REG_VIEW_ROW: view_row_q <= cfg_if.wr_data[COORD_BITS-2:0];
        rca_pkg::REG_VIEW_COL: view_col_q <= cfg_if.wr_data[COORD_BITS-2:0];
        default: ;
      endcase
    end
  end

  // Accept a position whenever the chain can advance
  assign pos_if.ready = en;

  rca_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (pos_if.valid),
    .row_i      (pos_if.cell_row_half),
    .col_i      (pos_if.cell_col_half),
    .view_row_i (view_row_q),
    .view_col_i (view_col_q),
    .side_o     (side_s[0]),
    .x_o        (x_s[0]),
    .y_o        (y_s[0])
  );

  // Angle accumulation starts at zero
  assign z_s[0] = '0;

  // One cell per micro-rotation; the last one hands on only its angle and its sideband
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    if (g < CORDIC_STAGES - 1) begin : g_mid
      rca_cell #(
        .STAGE (g)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .side_i (side_s[g]),
        .x_i    (x_s[g]),
        .y_i    (y_s[g]),
        .z_i    (z_s[g]),
        .side_o (side_s[g+1]),
        .x_o    (x_s[g+1]),
        .y_o    (y_s[g+1]),
        .z_o    (z_s[g+1])
      );
    end else begin : g_last
      rca_cell #(
        .STAGE (g)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .side_i (side_s[g]),
        .x_i    (x_s[g]),
        .y_i    (y_s[g]),
        .z_i    (z_s[g]),
        .side_o (side_s[g+1]),
        .x_o    (),
        .y_o    (),
        .z_o    (z_s[g+1])
      );
    end
  end

  rca_fold #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_fold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (side_s[CORDIC_STAGES]),
    .z_i    (z_s[CORDIC_STAGES]),
    .en_o   (en),
    .azi_if (azi_if)
  );

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_if.valid && pos_if.ready) |=> side_s[0].valid)
    else $error("accepted position word did not enter the front cell");

  a_view_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (azi_if.valid && azi_if.at_viewpoint) |-> (azi_if.azimuth == '0))
    else $error("viewpoint flag set with a nonzero azimuth");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(side_s[0]))
    else $error("front cell moved while the chain was stalled");

endmodule

FILE: sv/rca_front.sv
// Front cell: offsets from the viewpoint, sector classification, scaled magnitudes.
module rca_front #(
  parameter int unsigned COORD_BITS = rca_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [COORD_BITS-1:0]               row_i,
  input  logic [COORD_BITS-1:0]               col_i,
  input  logic [COORD_BITS-2:0]               view_row_i,
  input  logic [COORD_BITS-2:0]               view_col_i,
  output rca_pkg::side_t                      side_o,
  output logic signed [rca_pkg::XY_BITS-1:0]  x_o,
  output logic signed [rca_pkg::XY_BITS-1:0]  y_o
);

  localparam int unsigned GUARD = rca_pkg::GUARD_TOP - COORD_BITS;

  logic signed [COORD_BITS:0]       dx, dy;
  logic [COORD_BITS-1:0]            adx, ady;
  logic [rca_pkg::XY_BITS-1:0]      adx_ext, ady_ext;
  rca_pkg::kind_e                   kind;
  rca_pkg::side_t                   side_d, side_q;
  logic signed [rca_pkg::XY_BITS-1:0] x_q, y_q;

  always_comb begin
    dy = signed'({1'b0, view_row_i, 1'b0}) - signed'({1'b0, row_i});
    dx = signed'({1'b0, col_i}) - signed'({1'b0, view_col_i, 1'b0});
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    adx_ext = rca_pkg::XY_BITS'(adx);
    ady_ext = rca_pkg::XY_BITS'(ady);
  end

  always_comb begin
    if (dx == '0 && dy == '0) begin
      kind = rca_pkg::KIND_VIEW;
    end else if (dy == '0) begin
      kind = dx[COORD_BITS] ? rca_pkg::KIND_AXIS_W : rca_pkg::KIND_AXIS_E;
    end else if (dx == '0) begin
      kind = dy[COORD_BITS] ? rca_pkg::KIND_AXIS_S : rca_pkg::KIND_AXIS_N;
    end else if (!dy[COORD_BITS]) begin
      kind = dx[COORD_BITS] ? rca_pkg::KIND_QUAD_NW : rca_pkg::KIND_QUAD_NE;
    end else begin
      kind = dx[COORD_BITS] ? rca_pkg::KIND_QUAD_SW : rca_pkg::KIND_QUAD_SE;
    end
    side_d.valid = valid_i;
    side_d.kind  = kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  // Scale the magnitudes up so the rotations keep full precision
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= signed'(adx_ext << GUARD);
      y_q <= signed'(ady_ext << GUARD);
    end
  end

  assign side_o = side_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

FILE: sv/rca_cell.sv
// Rotation cell: one vectoring micro-rotation with its angle step, registered.
module rca_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  rca_pkg::side_t                      side_i,
  input  logic signed [rca_pkg::XY_BITS-1:0]  x_i,
  input  logic signed [rca_pkg::XY_BITS-1:0]  y_i,
  input  logic signed [rca_pkg::Z_BITS-1:0]   z_i,
  output rca_pkg::side_t                      side_o,
  output logic signed [rca_pkg::XY_BITS-1:0]  x_o,
  output logic signed [rca_pkg::XY_BITS-1:0]  y_o,
  output logic signed [rca_pkg::Z_BITS-1:0]   z_o
);

  localparam logic signed [rca_pkg::Z_BITS-1:0] ANGLE =
    signed'(rca_pkg::Z_BITS'(rca_pkg::STAGE_ANGLE[STAGE]));

  logic signed [rca_pkg::XY_BITS-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [rca_pkg::Z_BITS-1:0]  z_d, z_q;
  rca_pkg::side_t                     side_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    // Turn clockwise while y is above the x axis, counter-clockwise otherwise
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANGLE;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign side_o = side_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

FILE: sv/rca_fold.sv
// Output cell: quadrant fold, rounding to the output width, output register and skid.
module rca_fold #(
  parameter int unsigned ANGLE_BITS = rca_pkg::ANGLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rca_pkg::side_t                     side_i,
  input  logic signed [rca_pkg::Z_BITS-1:0]  z_i,
  output logic                               en_o,
  rca_azi_if.source                          azi_if
);

  localparam int unsigned DROP = rca_pkg::TURN_BITS - ANGLE_BITS;
  localparam logic [rca_pkg::TURN_BITS-1:0] HALF_TURN =
    rca_pkg::TURN_BITS'(1) << (rca_pkg::TURN_BITS - 1);

  logic [rca_pkg::TURN_BITS-1:0] z_turn, full;
  logic [ANGLE_BITS-1:0]         rounded, az;
  logic                          flag;

  logic                  out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic                  load_out, load_skid, out_from_skid;
  logic [ANGLE_BITS-1:0] out_az_q, skid_az_q;
  logic                  out_flag_q, skid_flag_q;

  // Fold the in-quadrant angle onto the full turn, modulo one turn
  always_comb begin
    z_turn = z_i[rca_pkg::TURN_BITS-1:0];
    case (side_i.kind)
      rca_pkg::KIND_QUAD_NW: full = HALF_TURN - z_turn;
      rca_pkg::KIND_QUAD_SW: full = HALF_TURN + z_turn;
      rca_pkg::KIND_QUAD_SE: full = '0 - z_turn;
      default:               full = z_turn;
    endcase
  end

  generate
    if (DROP > 0) begin : g_round
      localparam logic [rca_pkg::TURN_BITS-1:0] ROUND_HALF =
        rca_pkg::TURN_BITS'(1) << (DROP - 1);
      logic [rca_pkg::TURN_BITS-1:0] sum;
      // Round half up; a carry past the top wraps to zero
      assign sum     = full + ROUND_HALF;
      assign rounded = sum[rca_pkg::TURN_BITS-1:DROP];
    end else begin : g_exact
      assign rounded = full;
    end
  endgenerate

  always_comb begin
    flag = 1'b0;
    case (side_i.kind)
      rca_pkg::KIND_VIEW: begin
        az   = '0;
        flag = 1'b1;
      end
      rca_pkg::KIND_AXIS_E: az = '0;
      rca_pkg::KIND_AXIS_N: az = {2'd1, (ANGLE_BITS-2)'(0)};
      rca_pkg::KIND_AXIS_W: az = {2'd2, (ANGLE_BITS-2)'(0)};
      rca_pkg::KIND_AXIS_S: az = {2'd3, (ANGLE_BITS-2)'(0)};
      default:              az = rounded;
    endcase
  end

  // Chain advances only while the skid is free
  assign en_o = !skid_valid_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (azi_if.ready) begin
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
        out_valid_d   = 1'b1;
      end
    end else if (!out_valid_q || azi_if.ready) begin
      out_valid_d = side_i.valid;
      load_out    = side_i.valid;
    end else if (side_i.valid) begin
      load_skid    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_az_q   <= az;
      out_flag_q <= flag;
    end else if (out_from_skid) begin
      out_az_q   <= skid_az_q;
      out_flag_q <= skid_flag_q;
    end
    if (load_skid) begin
      skid_az_q   <= az;
      skid_flag_q <= flag;
    end
  end

  assign azi_if.valid        = out_valid_q;
  assign azi_if.azimuth      = out_az_q;
  assign azi_if.at_viewpoint = out_flag_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !azi_if.ready) |=> (skid_valid_q && $stable(skid_az_q)))
    else $error("skid word lost or changed while the receiver stalls");

endmodule
